[rtl/substring_search_whole_word_macros.svh]
// Assertion macros for the checker file of the search block.
`ifndef SUBSTRING_SEARCH_WHOLE_WORD_MACROS_SVH
`define SUBSTRING_SEARCH_WHOLE_WORD_MACROS_SVH

// Checked only out of reset.
`define SSWW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SSWW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/ssww_pkg.sv]
// Types and constants of the whole-word substring search block.
`default_nettype none

package ssww_pkg;

  localparam int MAX_QUERY_BYTES_DEF = 16;
  localparam int OFFSET_BITS_DEF     = 16;
  localparam int CUE_INDEX_BITS_DEF  = 16;

  localparam int QUERY_SLOTS    = 16;
  localparam int LEN_W          = 5;
  localparam int OUT_W          = 16;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int RES_FIFO_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE_SENS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_WORD = 3'd4;

  typedef enum logic [1:0] {
    KIND_HIT         = 2'd0,
    KIND_BAD_UTF8    = 2'd1,
    KIND_EMPTY_QUERY = 2'd2
  } kind_e;

  // Range constraint on the first continuation byte of a sequence.
  typedef enum logic [2:0] {
    LIM_NONE  = 3'd0,
    LIM_A0_BF = 3'd1,
    LIM_80_9F = 3'd2,
    LIM_90_BF = 3'd3,
    LIM_80_8F = 3'd4
  } utf8_lim_e;

  typedef struct packed {
    kind_e             kind;
    logic [OUT_W-1:0]  cue;
    logic [OUT_W-1:0]  offset;
    logic [LEN_W-1:0]  len;
    logic              last;
  } res_t;

  typedef struct packed {
    logic shift;
    logic clear_class;
    logic fold_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/ssww_cell.sv]
// One window cell: holds a text byte and its word class, compares the incoming byte.
`default_nettype none

module ssww_cell import ssww_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_ctrl_t ctrl_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       class_i,
  input  wire logic [7:0] query_i,
  output logic      [7:0] byte_o,
  output logic            class_o,
  output logic            eq_o
);

  logic [7:0] byte_q;
  logic       cls_q;

  function automatic logic [7:0] fold(input logic [7:0] b, input logic en);
    if (en && b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'd32;
    end
    return b;
  endfunction

  // Compare against the byte this cell holds after the shift.
  assign eq_o    = fold(byte_i, ctrl_i.fold_en) == fold(query_i, ctrl_i.fold_en);
  assign byte_o  = byte_q;
  assign class_o = cls_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cls_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      cls_q <= ctrl_i.clear_class ? 1'b0 : class_i;
    end
  end

endmodule

`default_nettype wire

[rtl/ssww_utf8.sv]
// Strict UTF-8 checker for the text of one cue.
`default_nettype none

module ssww_utf8 import ssww_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output logic            ok_o
);

  logic [1:0] cnt_q, cnt_d;
  utf8_lim_e  lim_q, lim_d;
  logic [7:0] lo, hi;

  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    unique case (lim_q)
      LIM_A0_BF: lo = 8'hA0;
      LIM_80_9F: hi = 8'h9F;
      LIM_90_BF: lo = 8'h90;
      LIM_80_8F: hi = 8'h8F;
      default:   ;
    endcase
  end

  always_comb begin
    ok_o  = 1'b1;
    cnt_d = cnt_q;
    lim_d = lim_q;
    if (cnt_q != 2'd0) begin
      if (byte_i < lo || byte_i > hi) begin
        ok_o = 1'b0;
      end else begin
        lim_d = LIM_NONE;
        cnt_d = cnt_q - 2'd1;
      end
    end else if (byte_i < 8'h80) begin
      cnt_d = 2'd0;
    end else if (byte_i >= 8'hC2 && byte_i <= 8'hDF) begin
      cnt_d = 2'd1;
      lim_d = LIM_NONE;
    end else if (byte_i >= 8'hE0 && byte_i <= 8'hEF) begin
      cnt_d = 2'd2;
      lim_d = (byte_i == 8'hE0) ? LIM_A0_BF :
              (byte_i == 8'hED) ? LIM_80_9F : LIM_NONE;
    end else if (byte_i >= 8'hF0 && byte_i <= 8'hF4) begin
      cnt_d = 2'd3;
      lim_d = (byte_i == 8'hF0) ? LIM_90_BF :
              (byte_i == 8'hF4) ? LIM_80_8F : LIM_NONE;
    end else begin
      ok_o = 1'b0;
    end
    // A cue may not end inside a sequence.
    if (last_i && cnt_d != 2'd0) begin
      ok_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      lim_q <= LIM_NONE;
    end else if (step_i) begin
      if (last_i) begin
        cnt_q <= 2'd0;
        lim_q <= LIM_NONE;
      end else if (ok_o) begin
        cnt_q <= cnt_d;
        lim_q <= lim_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ssww_result_fifo.sv]
// Result queue: takes up to two results a cycle, hands out one.
`default_nettype none

module ssww_result_fifo import ssww_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] push_cnt_i,
  input  wire res_t       data0_i,
  input  wire res_t       data1_i,
  input  wire logic       pop_i,
  output logic            valid_o,
  output res_t            data_o,
  output logic            room2_o
);

  localparam int PtrW = $clog2(RES_FIFO_DEPTH);
  localparam int CntW = $clog2(RES_FIFO_DEPTH + 1);

  res_t            mem [RES_FIFO_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] count_q;
  logic [PtrW-1:0] wr_next;

  assign wr_next = wr_q + PtrW'(1);
  assign valid_o = count_q != '0;
  assign data_o  = mem[rd_q];
  assign room2_o = count_q <= CntW'(RES_FIFO_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem[wr_q] <= data0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem[wr_next] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + PtrW'(push_cnt_i);
      rd_q    <= rd_q + PtrW'(pop_i);
      count_q <= count_q + CntW'(push_cnt_i) - CntW'(pop_i);
    end
  end

endmodule

`default_nettype wire

[rtl/substring_search_whole_word.sv]
// Whole-word substring search over streamed caption cues, one byte per cycle.
// Throughput: one text byte per cycle while the result queue has room for two results.
// Each result enters the result queue when its text byte transfers and leaves it in order.
// Match compare runs in a row of window cells shifted once per byte.
// Reset (asynchronous, active low) clears config and stream registers, cell classes, counters and the queue.
`default_nettype none

module substring_search_whole_word import ssww_pkg::*; #(
  parameter int MAX_QUERY_BYTES = MAX_QUERY_BYTES_DEF,
  parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
  parameter int CUE_INDEX_BITS  = CUE_INDEX_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  text_valid_i,
  output logic                       text_ready_o,
  input  wire logic [7:0]            text_byte_i,
  input  wire logic                  last_of_cue_i,
  output logic                       result_valid_o,
  input  wire logic                  result_ready_i,
  output logic [1:0]                 result_kind_o,
  output logic [OUT_W-1:0]           cue_number_o,
  output logic [OUT_W-1:0]           match_offset_o,
  output logic [LEN_W-1:0]           match_length_o,
  output logic                       last_result_o
);

  localparam int CellIdxW = (MAX_QUERY_BYTES > 1) ? $clog2(MAX_QUERY_BYTES) : 1;
  localparam logic [4:0] GapLimit = 5'd31;

  // configuration
  logic [CFG_DATA_W-1:0] qlow_q, qhigh_q;
  logic [LEN_W-1:0]      qlen_q;
  logic                  case_q, whole_q;

  // stream state
  logic [OFFSET_BITS-1:0]    pos_q, pend_off_q;
  logic [CUE_INDEX_BITS-1:0] cue_q;
  logic [4:0]                gap_q;
  logic                      pend_q, locked_q;

  logic [7:0]       qarr [QUERY_SLOTS];
  logic [LEN_W-1:0] len_eff;
  logic             proc, utf_ok, len_zero, cls_new, shift;
  cell_ctrl_t       cell_ctrl;

  logic [7:0]                 cell_byte [MAX_QUERY_BYTES];
  logic [MAX_QUERY_BYTES-1:0] cell_cls, eq_vec, active_vec;

  logic       all_eq, match, hist_cls, res_a, res_b;
  logic [4:0] gap_inc;
  logic [LEN_W-1:0]       hsel;
  logic [OFFSET_BITS-1:0] start;
  logic [OFFSET_BITS+OUT_W-1:0] pos_ext, start_ext, pend_ext;
  logic [CUE_INDEX_BITS+OUT_W-1:0] cue_ext;

  logic [1:0] push_cnt;
  res_t       res0, res1, head;
  logic       room2;

  function automatic logic is_word(input logic [7:0] b);
    return (b >= 8'h80) || (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h41 && b <= 8'h5A) || (b == 8'h5F);
  endfunction

  for (genvar k = 0; k < QUERY_SLOTS; k++) begin : g_qarr
    if (k < 8) begin : g_lo
      assign qarr[k] = qlow_q[8*k +: 8];
    end else begin : g_hi
      assign qarr[k] = qhigh_q[8*(k-8) +: 8];
    end
  end

  assign len_eff = (qlen_q > LEN_W'(MAX_QUERY_BYTES)) ? LEN_W'(MAX_QUERY_BYTES) : qlen_q;

  assign text_ready_o = room2;
  assign proc         = text_valid_i && text_ready_o && !locked_q;
  assign len_zero     = len_eff == '0;
  assign cls_new      = is_word(text_byte_i);
  assign shift        = proc && !len_zero && utf_ok;

  assign cell_ctrl.shift       = shift;
  assign cell_ctrl.clear_class = last_of_cue_i;
  assign cell_ctrl.fold_en     = !case_q;

  ssww_utf8 u_utf8 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (proc && !len_zero),
    .byte_i (text_byte_i),
    .last_i (last_of_cue_i),
    .ok_o   (utf_ok)
  );

  // Cell j holds the byte j positions back; it meets query byte len-1-j.
  for (genvar j = 0; j < MAX_QUERY_BYTES; j++) begin : g_cell
    logic [LEN_W-1:0] qidx;
    logic [7:0]       in_byte;
    logic             in_cls;

    assign qidx          = len_eff - LEN_W'(j) - LEN_W'(1);
    assign active_vec[j] = LEN_W'(j) < len_eff;

    if (j == 0) begin : g_head
      assign in_byte = text_byte_i;
      assign in_cls  = cls_new;
    end else begin : g_link
      assign in_byte = cell_byte[j-1];
      assign in_cls  = cell_cls[j-1];
    end

    ssww_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .byte_i  (in_byte),
      .class_i (in_cls),
      .query_i (qarr[qidx[3:0]]),
      .byte_o  (cell_byte[j]),
      .class_o (cell_cls[j]),
      .eq_o    (eq_vec[j])
    );
  end

  assign all_eq   = &(eq_vec | ~active_vec);
  assign gap_inc  = (gap_q < GapLimit) ? gap_q + 5'd1 : gap_q;
  assign match    = (gap_inc >= len_eff) && all_eq;
  // class of the byte just before the match start, as held before the shift
  assign hsel     = len_eff - LEN_W'(1);
  assign hist_cls = cell_cls[hsel[CellIdxW-1:0]];
  assign start    = pos_q - OFFSET_BITS'(len_eff) + OFFSET_BITS'(1);

  assign pos_ext   = {{OUT_W{1'b0}}, pos_q};
  assign start_ext = {{OUT_W{1'b0}}, start};
  assign pend_ext  = {{OUT_W{1'b0}}, pend_off_q};
  assign cue_ext   = {{OUT_W{1'b0}}, cue_q};

  assign res_a = pend_q && !cls_new;
  assign res_b = match && (!whole_q || (!hist_cls && last_of_cue_i));

  always_comb begin
    push_cnt = 2'd0;
    res0     = '0;
    res1     = '0;
    res0.cue = cue_ext[OUT_W-1:0];
    res1.cue = cue_ext[OUT_W-1:0];
    if (proc) begin
      if (len_zero) begin
        push_cnt  = 2'd1;
        res0.kind = KIND_EMPTY_QUERY;
        res0.last = 1'b1;
      end else if (!utf_ok) begin
        push_cnt    = 2'd1;
        res0.kind   = KIND_BAD_UTF8;
        res0.offset = pos_ext[OUT_W-1:0];
        res0.last   = 1'b1;
      end else begin
        // held hit goes out ahead of a hit ending on this byte
        res1.kind   = KIND_HIT;
        res1.offset = start_ext[OUT_W-1:0];
        res1.len    = len_eff;
        res1.last   = 1'b1;
        if (res_a) begin
          res0.kind   = KIND_HIT;
          res0.offset = pend_ext[OUT_W-1:0];
          res0.len    = len_eff;
          res0.last   = !res_b;
          push_cnt    = res_b ? 2'd2 : 2'd1;
        end else if (res_b) begin
          res0     = res1;
          push_cnt = 2'd1;
        end
      end
    end
  end

  ssww_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .data0_i    (res0),
    .data1_i    (res1),
    .pop_i      (result_valid_o && result_ready_i),
    .valid_o    (result_valid_o),
    .data_o     (head),
    .room2_o    (room2)
  );

  assign result_kind_o  = head.kind;
  assign cue_number_o   = head.cue;
  assign match_offset_o = head.offset;
  assign match_length_o = head.len;
  assign last_result_o  = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlow_q  <= '0;
      qhigh_q <= '0;
      qlen_q  <= '0;
      case_q  <= 1'b0;
      whole_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_QUERY_LOW:  qlow_q  <= cfg_data_i;
        CFG_QUERY_HIGH: qhigh_q <= cfg_data_i;
        CFG_QUERY_LEN:  qlen_q  <= cfg_data_i[LEN_W-1:0];
        CFG_CASE_SENS:  case_q  <= cfg_data_i[0];
        CFG_WHOLE_WORD: whole_q <= cfg_data_i[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      pend_off_q <= '0;
      cue_q      <= '0;
      gap_q      <= '0;
      pend_q     <= 1'b0;
      locked_q   <= 1'b0;
    end else if (proc) begin
      if (len_zero || !utf_ok) begin
        locked_q <= 1'b1;
        pend_q   <= 1'b0;
      end else begin
        pend_q <= match && whole_q && !hist_cls && !last_of_cue_i;
        if (match) begin
          pend_off_q <= start;
        end
        if (last_of_cue_i) begin
          pos_q <= '0;
          gap_q <= '0;
          cue_q <= cue_q + CUE_INDEX_BITS'(1);
        end else begin
          pos_q <= pos_q + OFFSET_BITS'(1);
          gap_q <= match ? 5'd0 : gap_inc;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ssww_sva.sv]
// Port-level assertion checker for the search block, with its bind.
`default_nettype none

`include "substring_search_whole_word_macros.svh"

module ssww_sva import ssww_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  cfg_we_i,
  input wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input wire logic                  text_valid_i,
  input wire logic                  text_ready_o,
  input wire logic [7:0]            text_byte_i,
  input wire logic                  last_of_cue_i,
  input wire logic                  result_valid_o,
  input wire logic                  result_ready_i,
  input wire logic [1:0]            result_kind_o,
  input wire logic [OUT_W-1:0]      cue_number_o,
  input wire logic [OUT_W-1:0]      match_offset_o,
  input wire logic [LEN_W-1:0]      match_length_o,
  input wire logic                  last_result_o
);

  logic stall, text_xfer, err_xfer;

  assign stall     = result_valid_o && !result_ready_i;
  assign text_xfer = text_valid_i && text_ready_o;
  assign err_xfer  = result_valid_o && result_ready_i && result_kind_o != KIND_HIT;

  `SSWW_ASSERT(a_hold_stalled, stall |=> result_valid_o && $stable(match_offset_o) && $stable(result_kind_o), "stalled result changed")
  `SSWW_ASSERT(a_no_spurious, !result_valid_o && !text_xfer |=> !result_valid_o, "result without a text transfer")
  `SSWW_ASSERT(a_error_final, err_xfer |=> !result_valid_o, "result after an error result")
  `SSWW_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !result_valid_o, "result valid in reset")

endmodule

bind substring_search_whole_word ssww_sva u_ssww_sva (.*);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the whole-word substring search block.
module testbench;
  import ssww_pkg::*;

  // Tracks the search state, predicts results per text byte and checks them.
  class match_scoreboard;
    logic [63:0] q_low, q_high;
    logic [4:0]  q_len;
    logic        fold_off, whole_only;

    logic [7:0]  win [16];
    logic [16:0] word_hist;
    int unsigned utf8_need;
    utf8_lim_e   utf8_lim;
    logic [15:0] byte_pos, cue_num, pend_off;
    int unsigned gap;
    bit          pend_valid, locked;

    res_t        due_results [$];
    int unsigned mismatches;

    function new();
      int i;
      q_low = '0; q_high = '0; q_len = '0; fold_off = 1'b0; whole_only = 1'b0;
      for (i = 0; i < 16; i++) win[i] = 8'h00;
      word_hist = '0; utf8_need = 0; utf8_lim = LIM_NONE;
      byte_pos = '0; cue_num = '0; pend_off = '0; gap = 0;
      pend_valid = 1'b0; locked = 1'b0; mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_QUERY_LOW:  q_low = data;
        CFG_QUERY_HIGH: q_high = data;
        CFG_QUERY_LEN:  q_len = data[4:0];
        CFG_CASE_SENS:  fold_off = data[0];
        CFG_WHOLE_WORD: whole_only = data[0];
        default: ;
      endcase
    endfunction

    function logic [7:0] fold_byte(logic [7:0] b);
      if (!fold_off && b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
      return b;
    endfunction

    function bit word_char(logic [7:0] b);
      return b >= 8'h80 || (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h7A) ||
             (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
    endfunction

    function logic [7:0] query_at(int i);
      return (i < 8) ? q_low[8*i +: 8] : q_high[8*(i-8) +: 8];
    endfunction

    // Strict UTF-8 decoder step; 0 when the byte breaks the cue.
    function bit utf8_ok(logic [7:0] b, bit last);
      logic [7:0] lo, hi;
      lo = 8'h80;
      hi = 8'hBF;
      if (utf8_need != 0) begin
        case (utf8_lim)
          LIM_A0_BF: lo = 8'hA0;
          LIM_80_9F: hi = 8'h9F;
          LIM_90_BF: lo = 8'h90;
          LIM_80_8F: hi = 8'h8F;
          default: ;
        endcase
        if (b < lo || b > hi) return 1'b0;
        utf8_lim = LIM_NONE;
        utf8_need--;
      end else if (b < 8'h80) begin
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        utf8_need = 1;
      end else if (b >= 8'hE0 && b <= 8'hEF) begin
        utf8_need = 2;
        utf8_lim = (b == 8'hE0) ? LIM_A0_BF : (b == 8'hED) ? LIM_80_9F : LIM_NONE;
      end else if (b >= 8'hF0 && b <= 8'hF4) begin
        utf8_need = 3;
        utf8_lim = (b == 8'hF0) ? LIM_90_BF : (b == 8'hF4) ? LIM_80_8F : LIM_NONE;
      end else begin
        return 1'b0;
      end
      return !(last && utf8_need != 0);
    endfunction

    function res_t make_res(kind_e k, logic [15:0] off, int len);
      res_t r;
      r.kind = k;
      r.cue = cue_num;
      r.offset = off;
      r.len = LEN_W'(len);
      r.last = 1'b0;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, bit last);
      res_t out [2];
      int n, len, i;
      bit cls, hit;
      logic [15:0] start;
      n = 0;
      if (locked) return;
      len = (q_len > 16) ? 16 : int'(q_len);
      if (len == 0) begin
        out[0] = make_res(KIND_EMPTY_QUERY, 16'd0, 0);
        out[0].last = 1'b1;
        due_results.insert(due_results.size(), out[0]);
        locked = 1'b1;
        return;
      end
      if (!utf8_ok(b, last)) begin
        out[0] = make_res(KIND_BAD_UTF8, byte_pos, 0);
        out[0].last = 1'b1;
        due_results.insert(due_results.size(), out[0]);
        locked = 1'b1;
        pend_valid = 1'b0;
        return;
      end
      cls = word_char(b);
      // a held hit is confirmed only by a non-word byte behind it
      if (pend_valid) begin
        if (!cls) begin
          out[n] = make_res(KIND_HIT, pend_off, len);
          n++;
        end
        pend_valid = 1'b0;
      end
      for (i = 15; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      word_hist = {word_hist[15:0], cls};
      if (gap < 31) gap++;
      if (gap >= len) begin
        hit = 1'b1;
        for (i = 0; i < len; i++)
          if (fold_byte(win[len-1-i]) != fold_byte(query_at(i))) hit = 1'b0;
        if (hit) begin
          start = byte_pos - 16'(len) + 16'd1;
          gap = 0;
          if (!whole_only) begin
            out[n] = make_res(KIND_HIT, start, len);
            n++;
          end else if (!word_hist[len]) begin
            if (last) begin
              out[n] = make_res(KIND_HIT, start, len);
              n++;
            end else begin
              pend_valid = 1'b1;
              pend_off = start;
            end
          end
        end
      end
      byte_pos++;
      if (last) begin
        byte_pos = '0;
        gap = 0;
        word_hist = '0;
        pend_valid = 1'b0;
        utf8_need = 0;
        utf8_lim = LIM_NONE;
        cue_num++;
      end
      for (i = 0; i < n; i++) begin
        out[i].last = (i == n - 1);
        due_results.insert(due_results.size(), out[i]);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d cue %0d offset %0d length %0d",
               got.kind, got.cue, got.offset, got.len);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind) begin
        $error("result_kind: expected %0d, got %0d", want.kind, got.kind);
        mismatches++;
      end
      if (got.cue !== want.cue) begin
        $error("cue_number: expected %0d, got %0d", want.cue, got.cue);
        mismatches++;
      end
      if (got.offset !== want.offset) begin
        $error("match_offset: expected %0d, got %0d", want.offset, got.offset);
        mismatches++;
      end
      if (got.len !== want.len) begin
        $error("match_length: expected %0d, got %0d", want.len, got.len);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last_result: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  text_valid_i;
  logic                  text_ready_o;
  logic [7:0]            text_byte_i;
  logic                  last_of_cue_i;
  logic                  result_valid_o;
  logic                  result_ready_i;
  logic [1:0]            result_kind_o;
  logic [OUT_W-1:0]      cue_number_o;
  logic [OUT_W-1:0]      match_offset_o;
  logic [LEN_W-1:0]      match_length_o;
  logic                  last_result_o;

  match_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  logic [7:0] cue_buf [$];
  logic [7:0] qtext [$];
  logic [7:0] chr [4];
  int chr_n;

  substring_search_whole_word u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .text_valid_i   (text_valid_i),
    .text_ready_o   (text_ready_o),
    .text_byte_i    (text_byte_i),
    .last_of_cue_i  (last_of_cue_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .result_kind_o  (result_kind_o),
    .cue_number_o   (cue_number_o),
    .match_offset_o (match_offset_o),
    .match_length_o (match_length_o),
    .last_result_o  (last_result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    result_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      result_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && result_ready_i)
      sb.check_result({result_kind_o, cue_number_o, match_offset_o, match_length_o,
                       last_result_o});
  end

  // Entered and left right after a falling edge; valid stays up after the transfer.
  task automatic send_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      text_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    text_valid_i <= 1'b1;
    text_byte_i <= b;
    last_of_cue_i <= last;
    do @(posedge clk_i); while (!text_ready_o);
    sb.note_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s, input bit end_cue);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], end_cue && (i == s.len() - 1));
  endtask

  task automatic send_cue(input bit end_cue);
    int j;
    for (j = 0; j < cue_buf.size(); j++)
      send_byte(cue_buf[j], end_cue && (j == cue_buf.size() - 1));
  endtask

  task automatic drain();
    int w;
    text_valid_i <= 1'b0;
    for (w = 0; w < 5000 && sb.due_results.size() != 0; w++) @(negedge clk_i);
    // a byte without results may still be in flight
    repeat (4) @(negedge clk_i);
  endtask

  task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [4:0] len, input bit cs, input bit ww);
    logic [CFG_IDX_W-1:0]  idx [5];
    logic [CFG_DATA_W-1:0] val [5];
    int i;
    idx = '{CFG_QUERY_LOW, CFG_QUERY_HIGH, CFG_QUERY_LEN, CFG_CASE_SENS, CFG_WHOLE_WORD};
    val = '{lo, hi, {59'd0, len}, {63'd0, cs}, {63'd0, ww}};
    drain();
    for (i = 0; i < 5; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      sb.write_reg(idx[i], val[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 99) < 15)
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    case ($urandom_range(0, 3))
      0: return 8'h61;
      1: return 8'h62;
      2: return 8'h41;
      default: return 8'h42;
    endcase
  endfunction

  // Non-word bytes, including the neighbors of the letter and digit ranges.
  function automatic logic [7:0] pick_mark();
    case ($urandom_range(0, 12))
      0: return 8'h20;
      1: return 8'h2E;
      2: return 8'h2C;
      3: return 8'h2D;
      4: return 8'h0A;
      5: return 8'h00;
      6: return 8'h7F;
      7: return 8'h40;
      8: return 8'h5B;
      9: return 8'h60;
      10: return 8'h7B;
      11: return 8'h2F;
      default: return 8'h3A;
    endcase
  endfunction

  function automatic logic [7:0] first_cont(logic [7:0] lead);
    case (lead)
      8'hE0: return 8'($urandom_range(8'hA0, 8'hBF));
      8'hED: return 8'($urandom_range(8'h80, 8'h9F));
      8'hF0: return 8'($urandom_range(8'h90, 8'hBF));
      8'hF4: return 8'($urandom_range(8'h80, 8'h8F));
      default: return 8'($urandom_range(8'h80, 8'hBF));
    endcase
  endfunction

  task automatic make_char();
    int r;
    r = $urandom_range(0, 99);
    chr_n = 1;
    if (r < 40) chr[0] = pick_letter();
    else if (r < 48) chr[0] = 8'($urandom_range(8'h30, 8'h39));
    else if (r < 52) chr[0] = 8'h5F;
    else if (r < 72) chr[0] = pick_mark();
    else if (r < 84) begin
      chr_n = 2;
      chr[0] = 8'($urandom_range(8'hC2, 8'hDF));
      chr[1] = first_cont(chr[0]);
    end else if (r < 94) begin
      chr_n = 3;
      chr[0] = 8'($urandom_range(8'hE0, 8'hEF));
      chr[1] = first_cont(chr[0]);
      chr[2] = first_cont(8'h00);
    end else begin
      chr_n = 4;
      chr[0] = 8'($urandom_range(8'hF0, 8'hF4));
      chr[1] = first_cont(chr[0]);
      chr[2] = first_cont(8'h00);
      chr[3] = first_cont(8'h00);
    end
  endtask

  function automatic logic [7:0] flip_case(logic [7:0] b);
    if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) &&
        $urandom_range(0, 4) == 0)
      return b ^ 8'h20;
    return b;
  endfunction

  // Query from whole characters; unused slots get random bytes.
  task automatic pick_config();
    int n, j;
    logic [63:0] lo, hi;
    logic [7:0] qb;
    logic [4:0] len_val;
    case ($urandom_range(0, 7))
      0: n = 1;
      1: n = 16;
      default: n = $urandom_range(2, 6);
    endcase
    qtext.delete();
    while (qtext.size() < n) begin
      make_char();
      if (qtext.size() + chr_n <= n && $urandom_range(0, 2) != 0) begin
        for (j = 0; j < chr_n; j++) qtext.insert(qtext.size(), chr[j]);
      end else begin
        qtext.insert(qtext.size(), pick_letter());
      end
    end
    for (j = 0; j < 16; j++) begin
      qb = (j < n) ? qtext[j] : 8'($urandom_range(0, 255));
      if (j < 8) lo[8*j +: 8] = qb;
      else hi[8*(j-8) +: 8] = qb;
    end
    len_val = (n == 16 && $urandom_range(0, 1) == 1) ? 5'($urandom_range(17, 31)) : 5'(n);
    configure(lo, hi, len_val, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Random valid cue text, seeded with whole and partial copies of the query.
  task automatic build_cue();
    int goal, j, r, n;
    cue_buf.delete();
    goal = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 16);
    while (cue_buf.size() < goal) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        if ($urandom_range(0, 3) == 0) cue_buf.insert(cue_buf.size(), pick_mark());
        for (j = 0; j < qtext.size(); j++)
          cue_buf.insert(cue_buf.size(), flip_case(qtext[j]));
        if ($urandom_range(0, 3) == 0) cue_buf.insert(cue_buf.size(), pick_mark());
      end else if (r < 42) begin
        // prefix only: must not leave a multi-byte character open
        n = $urandom_range(1, qtext.size());
        while (n < qtext.size() && qtext[n][7:6] == 2'b10) n++;
        for (j = 0; j < n; j++) cue_buf.insert(cue_buf.size(), qtext[j]);
      end else begin
        make_char();
        for (j = 0; j < chr_n; j++) cue_buf.insert(cue_buf.size(), chr[j]);
      end
    end
  endtask

  task automatic random_phase(input int items);
    int sent, seg_goal;
    sent = 0;
    while (sent < items) begin
      pick_config();
      seg_goal = sent + $urandom_range(20, 80);
      while (sent < seg_goal) begin
        build_cue();
        send_cue(1'b1);
        sent += cue_buf.size();
      end
      // sometimes leave the cue open so the next settings apply mid-cue
      if ($urandom_range(0, 3) == 0) begin
        build_cue();
        send_cue(1'b0);
        sent += cue_buf.size();
      end
    end
  endtask

  task automatic directed_cases();
    int j;
    configure(64'h0074_6143, 64'h0, 5'd3, 1'b0, 1'b1);
    send_text("cat cAT", 1'b1);
    // both a held hit and a hit of its own on the second comma
    configure(64'h2C, 64'h0, 5'd1, 1'b1, 1'b1);
    send_text(",,", 1'b1);
    send_text(",", 1'b0);
    // held hit reports the length written meanwhile
    configure(64'h6261, 64'h0, 5'd2, 1'b0, 1'b0);
    send_text(" ", 1'b1);
    // full-size query, length above the maximum, extreme UTF-8 forms
    configure(64'h80C2_BFBF_8FF4_7F00, 64'h5A41_BF9F_ED80_A0E0, 5'd31, 1'b1, 1'b1);
    for (j = 0; j < 16; j++) send_byte(sb.query_at(j), j == 15);
  endtask

  // Ends the useful part of the run: any error locks the block until reset.
  task automatic break_stream();
    int mode, k;
    logic [7:0] lead, bad;
    mode = $urandom_range(0, 3);
    configure(64'h6261, 64'h0, (mode == 0) ? 5'd0 : 5'd2, 1'b0, 1'b1);
    send_text("ab", 1'b0);
    case (mode)
      1: send_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                        : 8'($urandom_range(8'hF5, 8'hFF)), 1'b0);
      2: begin
        case ($urandom_range(0, 4))
          0: begin lead = 8'hE0; bad = 8'($urandom_range(8'h80, 8'h9F)); end
          1: begin lead = 8'hED; bad = 8'($urandom_range(8'hA0, 8'hBF)); end
          2: begin lead = 8'hF0; bad = 8'($urandom_range(8'h80, 8'h8F)); end
          3: begin lead = 8'hF4; bad = 8'($urandom_range(8'h90, 8'hBF)); end
          default: begin
            lead = 8'($urandom_range(8'hC2, 8'hDF));
            bad = $urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h7F))
                                       : 8'($urandom_range(8'hC0, 8'hFF));
          end
        endcase
        send_byte(lead, 1'b0);
        send_byte(bad, 1'b0);
      end
      3: send_byte(8'($urandom_range(8'hC2, 8'hF4)), 1'b1);
      default: ;
    endcase
    for (k = 0; k < 3; k++) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    sb = new();
    send_idle_pct = 18;
    recv_idle_pct = 64;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    text_valid_i = 1'b0;
    text_byte_i = 8'h00;
    last_of_cue_i = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed_cases();
    random_phase(360);
    send_idle_pct = 64;
    recv_idle_pct = 18;
    random_phase(360);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(360);
    break_stream();

    drain();
    if (sb.due_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.due_results.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
